[hw/rtl/spt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spt_pkg: shared types and constants for stereo point triangulation
// Field widths, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package spt_pkg;

    localparam int OUT_FRAC_BITS_DEF = 16;
    localparam int PIX_W             = 16;
    localparam int DIST_W            = 24;
    localparam int OUT_W             = 32;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 24;
    localparam int QUEUE_DEPTH       = 4;

    localparam logic [DIST_W-1:0] BASELINE_RST  = 24'd22938;
    localparam logic [PIX_W-1:0]  FOCAL_RST     = 16'd12204;
    localparam logic [PIX_W-1:0]  CENTER_X_RST  = 16'd10240;
    localparam logic [PIX_W-1:0]  CENTER_Y_RST  = 16'd5760;
    localparam logic [DIST_W-1:0] MAX_DEPTH_RST = 24'd13107200;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASELINE  = 3'd0,
        CFG_FOCAL     = 3'd1,
        CFG_CENTER_X  = 3'd2,
        CFG_CENTER_Y  = 3'd3,
        CFG_MAX_DEPTH = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [DIST_W-1:0] baseline;
        logic [PIX_W-1:0]  focal;
        logic [PIX_W-1:0]  center_x;
        logic [PIX_W-1:0]  center_y;
        logic [DIST_W-1:0] max_depth;
    } cfg_t;

    // one request handed from the front to the back
    typedef struct packed {
        logic [PIX_W-1:0] disp;
        logic             dx_neg;
        logic [PIX_W-1:0] dx_mag;
        logic             dy_neg;
        logic [PIX_W-1:0] dy_mag;
    } job_t;

endpackage

[hw/rtl/spt_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spt_front: request intake and classification
// Registers a keypoint pair, drops non-positive disparity, forms offsets.
// ----------------------------------------------------------------------------
module spt_front (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [spt_pkg::PIX_W-1:0] left_x,
    input  logic [spt_pkg::PIX_W-1:0] right_x,
    input  logic [spt_pkg::PIX_W-1:0] left_row,
    input  spt_pkg::cfg_t            cfg,
    input  logic                     q_full,
    output logic                     push,
    output spt_pkg::job_t            job
);

    logic                      fv_reg;
    logic [spt_pkg::PIX_W-1:0] lx_reg;
    logic [spt_pkg::PIX_W-1:0] rx_reg;
    logic [spt_pkg::PIX_W-1:0] row_reg;
    logic                      keep;
    logic                      advance;

    assign keep     = lx_reg > rx_reg;
    assign push     = fv_reg && keep && !q_full;
    assign advance  = !fv_reg || !keep || !q_full;
    assign s_tready = advance;

    always_comb begin
        job.disp = lx_reg - rx_reg;
        if (lx_reg >= cfg.center_x) begin
            job.dx_neg = 1'b0;
            job.dx_mag = lx_reg - cfg.center_x;
        end else begin
            job.dx_neg = 1'b1;
            job.dx_mag = cfg.center_x - lx_reg;
        end
        if (cfg.center_y >= row_reg) begin
            job.dy_neg = 1'b0;
            job.dy_mag = cfg.center_y - row_reg;
        end else begin
            job.dy_neg = 1'b1;
            job.dy_mag = row_reg - cfg.center_y;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg <= 1'b0;
        end else if (advance) begin
            fv_reg <= s_tvalid;
        end
        if (advance && s_tvalid) begin
            lx_reg  <= left_x;
            rx_reg  <= right_x;
            row_reg <= left_row;
        end
    end

endmodule

[hw/rtl/spt_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spt_fifo: short request queue between front and back
// Register-based FIFO, first word fall-through.
// ----------------------------------------------------------------------------
module spt_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = spt_pkg::QUEUE_DEPTH
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] wdata,
    input  logic         pop,
    output logic [W-1:0] rdata,
    output logic         full,
    output logic         empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg;
    logic [PTR_W-1:0] rd_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = count_reg == CNT_W'(DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            if (do_push) begin
                wr_reg <= (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_reg <= (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            count_reg <= count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
        end
        if (do_push) begin
            mem_reg[wr_reg] <= wdata;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> count_reg == $past(count_reg) + CNT_W'($past(do_push))
                              - CNT_W'($past(do_pop)))
        else $error("queue count out of step");
    a_empty_ptr: assert property (@(posedge aclk) disable iff (!aresetn)
        empty |-> rd_reg == wr_reg)
        else $error("empty queue with unequal pointers");
`endif

endmodule

[hw/rtl/spt_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spt_div: pipelined restoring divider
// One quotient bit per stage, NUM_W stages, with a side tag carried along.
// ----------------------------------------------------------------------------
module spt_div #(
    parameter int NUM_W = 8,
    parameter int DEN_W = 8,
    parameter int TAG_W = 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_v,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic [TAG_W-1:0] tag,
    output logic             out_v,
    output logic [NUM_W-1:0] quo,
    output logic [TAG_W-1:0] tag_out
);

    localparam int WK_W = NUM_W + DEN_W;

    logic [WK_W-1:0]  work_reg [NUM_W];
    logic [DEN_W-1:0] den_reg  [NUM_W];
    logic [TAG_W-1:0] tag_reg  [NUM_W];
    logic             v_reg    [NUM_W];

    // shift in one numerator bit, subtract the divisor where it fits
    function automatic logic [WK_W-1:0] div_step(input logic [WK_W-1:0] w,
                                                 input logic [DEN_W-1:0] d);
        logic [WK_W:0]  t;
        logic [DEN_W:0] top;
        logic           q;
        t   = {w, 1'b0};
        top = t[WK_W:NUM_W];
        q   = top >= {1'b0, d};
        if (q) begin
            top = top - {1'b0, d};
        end
        return {top[DEN_W-1:0], t[NUM_W-1:1], q};
    endfunction

    for (genvar i = 0; i < NUM_W; i++) begin : g_stage
        if (i == 0) begin : g_first
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[i] <= 1'b0;
                end else if (en) begin
                    v_reg[i] <= in_v;
                end
                if (en) begin
                    work_reg[i] <= div_step({{DEN_W{1'b0}}, num}, den);
                    den_reg[i]  <= den;
                    tag_reg[i]  <= tag;
                end
            end
        end else begin : g_next
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[i] <= 1'b0;
                end else if (en) begin
                    v_reg[i] <= v_reg[i-1];
                end
                if (en) begin
                    work_reg[i] <= div_step(work_reg[i-1], den_reg[i-1]);
                    den_reg[i]  <= den_reg[i-1];
                    tag_reg[i]  <= tag_reg[i-1];
                end
            end
        end
    end

    assign out_v   = v_reg[NUM_W-1];
    assign quo     = work_reg[NUM_W-1][NUM_W-1:0];
    assign tag_out = tag_reg[NUM_W-1];

endmodule

[hw/rtl/spt_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spt_back: depth and offset computation
// Depth division, range check, two offset divisions, saturation, output.
// ----------------------------------------------------------------------------
module spt_back #(
    parameter int OUT_FRAC_BITS = spt_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  spt_pkg::cfg_t              cfg,
    input  logic                       q_empty,
    input  spt_pkg::job_t              job,
    output logic                       pop,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [spt_pkg::OUT_W-1:0]  lateral_q16,
    output logic [spt_pkg::DIST_W-1:0] depth_q16,
    output logic [spt_pkg::OUT_W-1:0]  height_q16
);

    localparam int UP      = (OUT_FRAC_BITS >= 16) ? OUT_FRAC_BITS - 16 : 0;
    localparam int DN      = (OUT_FRAC_BITS < 16) ? 16 - OUT_FRAC_BITS : 0;
    localparam int PW      = spt_pkg::PIX_W;
    localparam int DW      = spt_pkg::DIST_W;
    localparam int OW      = spt_pkg::OUT_W;
    localparam int D1_NUM  = DW + PW + 1;
    localparam int D2_NUM  = DW + PW + 1 + UP;
    localparam int D2_DEN  = PW + DN;
    localparam int TAG1_W  = 2 * PW + 2;

    logic                adv;
    logic                out_v_reg;
    logic [OW-1:0]       lat_reg;
    logic [DW-1:0]       dep_reg;
    logic [OW-1:0]       hgt_reg;

    logic                a_v_reg;
    logic [D1_NUM-1:0]   a_num_reg;
    logic [PW-1:0]       a_disp_reg;
    logic [TAG1_W-1:0]   a_tag_reg;

    logic                d1_v;
    logic [D1_NUM-1:0]   d1_q;
    logic [TAG1_W-1:0]   d1_tag;

    logic                b_v_reg;
    logic [D2_NUM-1:0]   b_numx_reg;
    logic [D2_NUM-1:0]   b_numy_reg;
    logic [DW:0]         b_tagx_reg;
    logic                b_tagy_reg;

    logic [D2_DEN-1:0]   den2;
    logic [DW-1:0]       depth_c;
    logic                dx_neg_c;
    logic [PW-1:0]       dx_mag_c;
    logic                dy_neg_c;
    logic [PW-1:0]       dy_mag_c;

    logic                d2x_v;
    logic [D2_NUM-1:0]   d2x_q;
    logic [DW:0]         d2x_tag;
    logic                d2y_v;
    logic [D2_NUM-1:0]   d2y_q;
    logic                d2y_tag;

    function automatic logic [OW-1:0] sat(input logic [D2_NUM-1:0] q, input logic neg);
        if (neg) begin
            if (q > D2_NUM'(33'h1_0000_0000 >> 1)) begin
                return {1'b1, {(OW-1){1'b0}}};
            end
            return ~q[OW-1:0] + 1'b1;
        end
        if (q > D2_NUM'({1'b0, {(OW-1){1'b1}}})) begin
            return {1'b0, {(OW-1){1'b1}}};
        end
        return q[OW-1:0];
    endfunction

    // whole back pipeline moves when the output register can take a result
    assign adv = !out_v_reg || m_tready;
    assign pop = adv && !q_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
        end else if (adv) begin
            a_v_reg <= !q_empty;
        end
        if (adv) begin
            a_num_reg  <= D1_NUM'(cfg.baseline * cfg.focal) + D1_NUM'(job.disp >> 1);
            a_disp_reg <= job.disp;
            a_tag_reg  <= {job.dx_neg, job.dx_mag, job.dy_neg, job.dy_mag};
        end
    end

    spt_div #(.NUM_W(D1_NUM), .DEN_W(PW), .TAG_W(TAG1_W)) u_div_depth (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv),
        .in_v    (a_v_reg),
        .num     (a_num_reg),
        .den     (a_disp_reg),
        .tag     (a_tag_reg),
        .out_v   (d1_v),
        .quo     (d1_q),
        .tag_out (d1_tag)
    );

    assign depth_c                                  = d1_q[DW-1:0];
    assign {dx_neg_c, dx_mag_c, dy_neg_c, dy_mag_c} = d1_tag;
    assign den2                                     = D2_DEN'(cfg.focal) << DN;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_v_reg <= 1'b0;
        end else if (adv) begin
            // drop points beyond the depth limit
            b_v_reg <= d1_v && (d1_q <= D1_NUM'(cfg.max_depth));
        end
        if (adv) begin
            b_numx_reg <= (D2_NUM'(depth_c * dx_mag_c) << UP) + D2_NUM'(den2 >> 1);
            b_numy_reg <= (D2_NUM'(depth_c * dy_mag_c) << UP) + D2_NUM'(den2 >> 1);
            b_tagx_reg <= {depth_c, dx_neg_c};
            b_tagy_reg <= dy_neg_c;
        end
    end

    spt_div #(.NUM_W(D2_NUM), .DEN_W(D2_DEN), .TAG_W(DW + 1)) u_div_lat (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv),
        .in_v    (b_v_reg),
        .num     (b_numx_reg),
        .den     (den2),
        .tag     (b_tagx_reg),
        .out_v   (d2x_v),
        .quo     (d2x_q),
        .tag_out (d2x_tag)
    );

    spt_div #(.NUM_W(D2_NUM), .DEN_W(D2_DEN), .TAG_W(1)) u_div_hgt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv),
        .in_v    (b_v_reg),
        .num     (b_numy_reg),
        .den     (den2),
        .tag     (b_tagy_reg),
        .out_v   (d2y_v),
        .quo     (d2y_q),
        .tag_out (d2y_tag)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (adv) begin
            out_v_reg <= d2x_v && d2y_v;
        end
        if (adv) begin
            dep_reg <= d2x_tag[DW:1];
            // zero focal length yields zero offsets
            lat_reg <= (cfg.focal == '0) ? '0 : sat(d2x_q, d2x_tag[0]);
            hgt_reg <= (cfg.focal == '0) ? '0 : sat(d2y_q, d2y_tag);
        end
    end

    assign m_tvalid    = out_v_reg;
    assign lateral_q16 = lat_reg;
    assign depth_q16   = dep_reg;
    assign height_q16  = hgt_reg;

endmodule

[hw/rtl/stereo_point_triangulation.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_point_triangulation: stereo keypoint pair to metric 3-D point
// Top level: configuration registers, front, request queue, back.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one matched pair per request; s_tdata holds
//   left_x [15:0], right_x [31:16], left_row [47:32], unsigned Q12.4.
//   m_* channel returns lateral [31:0], depth [55:32], height [87:56].
//   Pairs with non-positive disparity or depth above max_depth give no
//   result. cfg_* writes one register per request; write only while idle.
//   Throughput: one request per cycle while m_tready stays high. From
//   acceptance to m_tvalid a result passes the front register, queue,
//   bit-per-stage depth and offset dividers, and output register.
//   A stalled receiver freezes the back pipeline; a four-entry queue and
//   the front register absorb requests before s_tready drops.
//   Reset (aresetn low, synchronous) empties all stages and restores the
//   register defaults.
// ----------------------------------------------------------------------------
module stereo_point_triangulation #(
    parameter int OUT_FRAC_BITS = spt_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [47:0]                    s_tdata,   // left_x, right_x, left_row
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [87:0]                    m_tdata,   // lateral_q16, depth_q16, height_q16
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [spt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [spt_pkg::CFG_DATA_W-1:0] cfg_data
);

    spt_pkg::cfg_t                   cfg_reg;
    spt_pkg::job_t                   push_job;
    spt_pkg::job_t                   pop_job;
    logic                            push;
    logic                            pop;
    logic                            q_full;
    logic                            q_empty;
    logic [spt_pkg::OUT_W-1:0]       lateral_q16;
    logic [spt_pkg::DIST_W-1:0]      depth_q16;
    logic [spt_pkg::OUT_W-1:0]       height_q16;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.baseline  <= spt_pkg::BASELINE_RST;
            cfg_reg.focal     <= spt_pkg::FOCAL_RST;
            cfg_reg.center_x  <= spt_pkg::CENTER_X_RST;
            cfg_reg.center_y  <= spt_pkg::CENTER_Y_RST;
            cfg_reg.max_depth <= spt_pkg::MAX_DEPTH_RST;
        end else if (cfg_valid) begin
            case (spt_pkg::cfg_index_t'(cfg_index))
                spt_pkg::CFG_BASELINE:  cfg_reg.baseline  <= cfg_data;
                spt_pkg::CFG_FOCAL:     cfg_reg.focal     <= cfg_data[15:0];
                spt_pkg::CFG_CENTER_X:  cfg_reg.center_x  <= cfg_data[15:0];
                spt_pkg::CFG_CENTER_Y:  cfg_reg.center_y  <= cfg_data[15:0];
                spt_pkg::CFG_MAX_DEPTH: cfg_reg.max_depth <= cfg_data;
                default: ;
            endcase
        end
    end

    spt_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .left_x   (s_tdata[15:0]),
        .right_x  (s_tdata[31:16]),
        .left_row (s_tdata[47:32]),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .push     (push),
        .job      (push_job)
    );

    spt_fifo #(.W($bits(spt_pkg::job_t)), .DEPTH(spt_pkg::QUEUE_DEPTH)) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wdata   (push_job),
        .pop     (pop),
        .rdata   (pop_job),
        .full    (q_full),
        .empty   (q_empty)
    );

    spt_back #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .q_empty     (q_empty),
        .job         (pop_job),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .lateral_q16 (lateral_q16),
        .depth_q16   (depth_q16),
        .height_q16  (height_q16)
    );

    assign m_tdata = {height_q16, depth_q16, lateral_q16};

endmodule

[test/stereo_point_triangulation_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_point_triangulation_tb: self-checking bench for the triangulator
// Feeds keypoint pairs in random bursts, predicts each 3-D point from the
// current register set, and compares every returned point in order.
// ----------------------------------------------------------------------------
module stereo_point_triangulation_tb;

    localparam int FRAC      = 16;
    localparam int LATENCY   = 120;
    localparam int WDOG_MAX  = 20000;

    typedef struct packed {
        logic [31:0] height;
        logic [23:0] depth;
        logic [31:0] lateral;
    } point_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [87:0] m_tdata;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [spt_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [spt_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    logic [47:0]    pair_q[$];
    point_t         point_q[$];
    spt_pkg::cfg_t  cfg;
    int             errors = 0;
    int             burst = 0;
    int             gap = 0;
    int             stall_phase = 0;
    int             wdog = 0;

    stereo_point_triangulation uut (.*);

    always begin
        #10 aclk = 1;
        #10 aclk = 0;
    end

    // depth * delta / focal, rounded half away from zero, saturated
    function automatic logic [31:0] offset_of(logic [63:0] depth, longint delta,
                                              logic [63:0] focal);
        logic        neg;
        logic [63:0] mag, num, den, q;
        neg = delta < 0;
        mag = neg ? 64'(-delta) : 64'(delta);
        if (focal == 0 || mag == 0 || depth == 0) return '0;
        num = (depth * mag) << (FRAC - 16);
        den = focal;
        q = (num + den / 2) / den;
        if (neg) begin
            if (q > 64'h8000_0000) q = 64'h8000_0000;
            return 32'(64'd0 - q);
        end
        if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
        return q[31:0];
    endfunction

    function automatic void triangulate(logic [47:0] pair);
        logic [63:0] lx, rx, row, disp, depth;
        point_t      p;
        lx = 64'(pair[15:0]);
        rx = 64'(pair[31:16]);
        row = 64'(pair[47:32]);
        if (lx <= rx) return;
        disp = lx - rx;
        depth = (64'(cfg.baseline) * 64'(cfg.focal) + disp / 2) / disp;
        if (depth > 64'(cfg.max_depth)) return;
        p.lateral = offset_of(depth, longint'(lx) - longint'(cfg.center_x),
                              64'(cfg.focal));
        p.depth = depth[23:0];
        p.height = offset_of(depth, longint'(cfg.center_y) - longint'(row),
                             64'(cfg.focal));
        point_q.insert(point_q.size(), p);
    endfunction

    // request driver: bursts with random gaps
    always @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            triangulate(s_tdata);
            void'(pair_q.pop_front());
        end
        if (!(s_tvalid && !s_tready)) begin
            if (burst == 0 && gap > 0) begin
                gap <= gap - 1;
                s_tvalid <= 0;
            end else if (pair_q.size() > 0) begin
                s_tvalid <= 1;
                s_tdata <= pair_q[0];
                if (burst == 0) begin
                    burst <= $urandom_range(1, 30);
                    gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst <= burst - 1;
                end
            end else begin
                s_tvalid <= 0;
            end
        end
    end

    // result monitor with its own stall pattern
    always @(posedge aclk) begin
        point_t got, want;
        stall_phase <= stall_phase + 1;
        m_tready <= (stall_phase % 512 < 128) ? 1'b1
                  : ((stall_phase % 7) != 3 && $urandom_range(0, 3) != 0);
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (point_q.size() == 0) begin
                $error("unexpected point %h", m_tdata);
                errors++;
            end else begin
                want = point_q.pop_front();
                if (got.lateral !== want.lateral) begin
                    $error("lateral_q16 exp %h got %h", want.lateral, got.lateral);
                    errors++;
                end
                if (got.depth !== want.depth) begin
                    $error("depth_q16 exp %h got %h", want.depth, got.depth);
                    errors++;
                end
                if (got.height !== want.height) begin
                    $error("height_q16 exp %h got %h", want.height, got.height);
                    errors++;
                end
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
            || !aresetn)
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_MAX) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_reg(spt_pkg::cfg_index_t idx, logic [23:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        case (idx)
            spt_pkg::CFG_BASELINE:  cfg.baseline = val;
            spt_pkg::CFG_FOCAL:     cfg.focal = val[15:0];
            spt_pkg::CFG_CENTER_X:  cfg.center_x = val[15:0];
            spt_pkg::CFG_CENTER_Y:  cfg.center_y = val[15:0];
            spt_pkg::CFG_MAX_DEPTH: cfg.max_depth = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pair_q.size() != 0 || s_tvalid || point_q.size() != 0) @(posedge aclk);
        repeat (LATENCY) @(posedge aclk);
    endtask

    function automatic logic [47:0] pair_of(logic [15:0] lx, logic [15:0] rx,
                                            logic [15:0] row);
        return {row, rx, lx};
    endfunction

    function automatic void add_pair(logic [47:0] pair);
        pair_q.insert(pair_q.size(), pair);
    endfunction

    // mostly positive disparity of moderate size, some noise
    function automatic logic [47:0] random_pair();
        logic [15:0] lx, rx;
        int          kind;
        kind = $urandom_range(0, 9);
        lx = 16'($urandom);
        if (kind < 6) begin
            rx = lx - 16'($urandom_range(1, (kind < 3) ? 2000 : 65535));
            if (rx >= lx) rx = 0;
        end else if (kind < 8) begin
            rx = lx - 16'($urandom_range(1, 16));
        end else begin
            rx = 16'($urandom);
        end
        return pair_of(lx, rx, 16'($urandom));
    endfunction

    task automatic run_random(int n);
        repeat (n) add_pair(random_pair());
        drain();
    endtask

    initial begin
        cfg = '{spt_pkg::BASELINE_RST, spt_pkg::FOCAL_RST, spt_pkg::CENTER_X_RST,
                spt_pkg::CENTER_Y_RST, spt_pkg::MAX_DEPTH_RST};
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: field extremes, dropped pairs, on-axis points
        add_pair(pair_of(16'd100, 16'd100, 16'd0));       // zero disparity
        add_pair(pair_of(16'd100, 16'd200, 16'd0));       // negative
        add_pair(pair_of(16'hFFFF, 16'd0, 16'hFFFF));
        add_pair(pair_of(16'hFFFF, 16'hFFFE, 16'd0));     // deepest
        add_pair(pair_of(16'd10240, 16'd9000, 16'd5760)); // on axis
        add_pair(pair_of(16'd1, 16'd0, 16'd0));
        add_pair(pair_of(16'd20000, 16'd19900, 16'd100));
        add_pair(pair_of(16'd0, 16'hFFFF, 16'hFFFF));
        drain();
        run_random(300);

        // extremes of the registers
        write_reg(spt_pkg::CFG_BASELINE, 24'hFFFFFF);
        write_reg(spt_pkg::CFG_FOCAL, 24'hFFFF);
        write_reg(spt_pkg::CFG_CENTER_X, 24'd0);
        write_reg(spt_pkg::CFG_CENTER_Y, 24'hFFFF);
        write_reg(spt_pkg::CFG_MAX_DEPTH, 24'hFFFFFF);
        add_pair(pair_of(16'hFFFF, 16'd0, 16'd0));
        run_random(250);

        write_reg(spt_pkg::CFG_FOCAL, 24'd0);                      // zero focal
        write_reg(spt_pkg::CFG_MAX_DEPTH, 24'd0);
        write_reg(spt_pkg::CFG_CENTER_X, 24'hFFFF);
        write_reg(spt_pkg::CFG_CENTER_Y, 24'd0);
        run_random(150);

        write_reg(spt_pkg::CFG_BASELINE, 24'd0);
        write_reg(spt_pkg::CFG_FOCAL, 24'd1);
        run_random(100);

        repeat (3) begin
            write_reg(spt_pkg::CFG_BASELINE, 24'($urandom_range(1000, 200000)));
            write_reg(spt_pkg::CFG_FOCAL, 24'($urandom_range(1, 65535)));
            write_reg(spt_pkg::CFG_CENTER_X, 24'($urandom_range(0, 65535)));
            write_reg(spt_pkg::CFG_CENTER_Y, 24'($urandom_range(0, 65535)));
            write_reg(spt_pkg::CFG_MAX_DEPTH, 24'($urandom));
            run_random(150);
        end

        if (point_q.size() != 0) errors++;
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
